>>> hdl/cmie_pkg.sv
// Card machine executor package: sizes, codes, control word and flag types,
// the microcode table and the dispatch maps.
// Depends on nothing; used by cmie_seq, cmie_dp and the top level.
package cmie_pkg;

	localparam int MEM_WORDS   = 100;
	localparam int BLOCK_WORDS = 10;
	localparam int BLOCK_BYTES = BLOCK_WORDS * 4;
	localparam int AW          = 7;
	localparam int UPC_W       = 5;

	localparam logic [7:0] CH_NL   = 8'h0A;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] OP_GD   = 8'h47;
	localparam logic [7:0] OP_PD   = 8'h50;
	localparam logic [7:0] OP_H    = 8'h48;
	localparam logic [7:0] OP_LR   = 8'h4C;
	localparam logic [7:0] OP_SR   = 8'h53;
	localparam logic [7:0] OP_CR   = 8'h43;
	localparam logic [7:0] OP_BT   = 8'h42;

	typedef enum logic [1:0] {
		K_CLEAR = 2'd0,
		K_PROG  = 2'd1,
		K_RUN   = 2'd2,
		K_DATA  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_RUN   = 2'd0,
		ST_AWAIT = 2'd1,
		ST_HALT  = 2'd2,
		ST_BAD   = 2'd3
	} stat_t;

	typedef enum logic [1:0] {
		N_SEQ,
		N_JUMP,
		N_OPMAP,
		N_END
	} nxt_t;

	typedef enum logic [2:0] {
		C_AWAIT,
		C_NOT_AWAIT,
		C_STOP,
		C_BLK_BAD,
		C_ADDR_BAD,
		C_FULL,
		C_NOT_CARD_END,
		C_PD_MORE
	} cnd_t;

	typedef enum logic [2:0] {
		A_IC,
		A_LOAD,
		A_FILL,
		A_OPER,
		A_PD
	} asel_t;

	typedef enum logic {
		D_BYTE,
		D_GR
	} dsel_t;

	typedef enum logic [3:0] {
		ACT_NONE,
		ACT_CLEAR,
		ACT_LOAD_ADV,
		ACT_LOAD_EOL,
		ACT_FILL_ADV,
		ACT_CARD_DONE,
		ACT_FETCH,
		ACT_SET_GD,
		ACT_PD_INIT,
		ACT_PD_ADV,
		ACT_HALT,
		ACT_LR,
		ACT_CMP,
		ACT_BT
	} act_t;

	typedef enum logic [1:0] {
		EM_NONE,
		EM_PLAIN,
		EM_NL,
		EM_PDBYTE
	} emit_t;

	typedef struct packed {
		nxt_t             nxt;
		cnd_t             cnd;
		logic [UPC_W-1:0] tgt;
		logic             rd;
		logic             wr;
		asel_t            asel;
		dsel_t            dsel;
		act_t             act;
		emit_t            emit;
		stat_t            stat;
		logic             last;
	} ctl_t;

	typedef struct packed {
		logic       await;
		logic       stop;
		logic       blk_ok;
		logic       addr_ok;
		logic       full;
		logic       card_end;
		logic       pd_more;
		logic [7:0] op;
	} flags_t;

	localparam logic [UPC_W-1:0] U_CLR  = 5'd0;
	localparam logic [UPC_W-1:0] U_PB0  = 5'd1;
	localparam logic [UPC_W-1:0] U_PB1  = 5'd2;
	localparam logic [UPC_W-1:0] U_PBF  = 5'd3;
	localparam logic [UPC_W-1:0] U_DB0  = 5'd4;
	localparam logic [UPC_W-1:0] U_DB1  = 5'd5;
	localparam logic [UPC_W-1:0] U_DB2  = 5'd6;
	localparam logic [UPC_W-1:0] U_NONE = 5'd7;
	localparam logic [UPC_W-1:0] U_RUN0 = 5'd8;
	localparam logic [UPC_W-1:0] U_RUN1 = 5'd9;
	localparam logic [UPC_W-1:0] U_RUN2 = 5'd10;
	localparam logic [UPC_W-1:0] U_RUN3 = 5'd11;
	localparam logic [UPC_W-1:0] U_GD   = 5'd12;
	localparam logic [UPC_W-1:0] U_GD1  = 5'd13;
	localparam logic [UPC_W-1:0] U_PD   = 5'd14;
	localparam logic [UPC_W-1:0] U_PD1  = 5'd15;
	localparam logic [UPC_W-1:0] U_PD2  = 5'd16;
	localparam logic [UPC_W-1:0] U_PD3  = 5'd17;
	localparam logic [UPC_W-1:0] U_H    = 5'd18;
	localparam logic [UPC_W-1:0] U_H1   = 5'd19;
	localparam logic [UPC_W-1:0] U_LR   = 5'd20;
	localparam logic [UPC_W-1:0] U_LR1  = 5'd21;
	localparam logic [UPC_W-1:0] U_SR   = 5'd22;
	localparam logic [UPC_W-1:0] U_SR1  = 5'd23;
	localparam logic [UPC_W-1:0] U_CR   = 5'd24;
	localparam logic [UPC_W-1:0] U_CR1  = 5'd25;
	localparam logic [UPC_W-1:0] U_BT   = 5'd26;
	localparam logic [UPC_W-1:0] U_BT1  = 5'd27;
	localparam logic [UPC_W-1:0] U_NOP  = 5'd28;
	localparam logic [UPC_W-1:0] U_BAD  = 5'd29;
	localparam logic [UPC_W-1:0] U_RAW  = 5'd30;
	localparam logic [UPC_W-1:0] U_RHL  = 5'd31;

	function automatic ctl_t ctl_idle();
		ctl_t c;
		c.nxt  = N_END;
		c.cnd  = C_AWAIT;
		c.tgt  = U_NONE;
		c.rd   = 1'b0;
		c.wr   = 1'b0;
		c.asel = A_IC;
		c.dsel = D_BYTE;
		c.act  = ACT_NONE;
		c.emit = EM_NONE;
		c.stat = ST_RUN;
		c.last = 1'b0;
		return c;
	endfunction

	function automatic ctl_t ucode(input logic [UPC_W-1:0] a);
		ctl_t c;
		c = ctl_idle();
		case (a)
			U_CLR: begin
				c.act = ACT_CLEAR;
			end
			U_PB0: begin
				c.nxt = N_JUMP; c.cnd = C_FULL; c.tgt = U_PBF;
				c.rd = 1'b1; c.asel = A_LOAD;
			end
			U_PB1: begin
				c.wr = 1'b1; c.asel = A_LOAD; c.act = ACT_LOAD_ADV;
			end
			U_PBF: begin
				c.act = ACT_LOAD_EOL;
			end
			U_DB0: begin
				c.nxt = N_JUMP; c.cnd = C_NOT_AWAIT; c.tgt = U_NONE;
				c.rd = 1'b1; c.asel = A_FILL;
			end
			U_DB1: begin
				c.nxt = N_JUMP; c.cnd = C_NOT_CARD_END; c.tgt = U_NONE;
				c.wr = 1'b1; c.asel = A_FILL; c.act = ACT_FILL_ADV;
			end
			U_DB2: begin
				c.act = ACT_CARD_DONE; c.emit = EM_PLAIN; c.last = 1'b1;
			end
			U_NONE: begin
				c.nxt = N_END;
			end
			U_RUN0: begin
				c.nxt = N_JUMP; c.cnd = C_AWAIT; c.tgt = U_RAW;
			end
			U_RUN1: begin
				c.nxt = N_JUMP; c.cnd = C_STOP; c.tgt = U_RHL;
				c.rd = 1'b1; c.asel = A_IC;
			end
			U_RUN2: begin
				c.nxt = N_SEQ; c.act = ACT_FETCH;
			end
			U_RUN3: begin
				c.nxt = N_OPMAP;
			end
			U_GD: begin
				c.nxt = N_JUMP; c.cnd = C_BLK_BAD; c.tgt = U_BAD;
			end
			U_GD1: begin
				c.act = ACT_SET_GD; c.emit = EM_PLAIN; c.stat = ST_AWAIT; c.last = 1'b1;
			end
			U_PD: begin
				c.nxt = N_JUMP; c.cnd = C_BLK_BAD; c.tgt = U_BAD; c.act = ACT_PD_INIT;
			end
			U_PD1: begin
				c.nxt = N_SEQ; c.rd = 1'b1; c.asel = A_PD;
			end
			U_PD2: begin
				c.nxt = N_JUMP; c.cnd = C_PD_MORE; c.tgt = U_PD1;
				c.act = ACT_PD_ADV; c.emit = EM_PDBYTE;
			end
			U_PD3: begin
				c.emit = EM_NL; c.last = 1'b1;
			end
			U_H: begin
				c.nxt = N_SEQ; c.act = ACT_HALT; c.emit = EM_NL; c.stat = ST_HALT;
			end
			U_H1: begin
				c.emit = EM_NL; c.stat = ST_HALT; c.last = 1'b1;
			end
			U_LR: begin
				c.nxt = N_JUMP; c.cnd = C_ADDR_BAD; c.tgt = U_BAD;
				c.rd = 1'b1; c.asel = A_OPER;
			end
			U_LR1: begin
				c.act = ACT_LR; c.emit = EM_PLAIN; c.last = 1'b1;
			end
			U_SR: begin
				c.nxt = N_JUMP; c.cnd = C_ADDR_BAD; c.tgt = U_BAD;
			end
			U_SR1: begin
				c.wr = 1'b1; c.asel = A_OPER; c.dsel = D_GR;
				c.emit = EM_PLAIN; c.last = 1'b1;
			end
			U_CR: begin
				c.nxt = N_JUMP; c.cnd = C_ADDR_BAD; c.tgt = U_BAD;
				c.rd = 1'b1; c.asel = A_OPER;
			end
			U_CR1: begin
				c.act = ACT_CMP; c.emit = EM_PLAIN; c.last = 1'b1;
			end
			U_BT: begin
				c.nxt = N_JUMP; c.cnd = C_ADDR_BAD; c.tgt = U_BAD;
			end
			U_BT1: begin
				c.act = ACT_BT; c.emit = EM_PLAIN; c.last = 1'b1;
			end
			U_NOP: begin
				c.emit = EM_PLAIN; c.last = 1'b1;
			end
			U_BAD: begin
				c.emit = EM_PLAIN; c.stat = ST_BAD; c.last = 1'b1;
			end
			U_RAW: begin
				c.emit = EM_PLAIN; c.stat = ST_AWAIT; c.last = 1'b1;
			end
			U_RHL: begin
				c.emit = EM_PLAIN; c.stat = ST_HALT; c.last = 1'b1;
			end
			default: begin
				c = ctl_idle();
			end
		endcase
		return c;
	endfunction

	function automatic logic [UPC_W-1:0] kind_entry(input kind_t k);
		logic [UPC_W-1:0] e;
		case (k)
			K_CLEAR: e = U_CLR;
			K_PROG:  e = U_PB0;
			K_RUN:   e = U_RUN0;
			K_DATA:  e = U_DB0;
			default: e = U_NONE;
		endcase
		return e;
	endfunction

	function automatic logic [UPC_W-1:0] op_entry(input logic [7:0] op);
		logic [UPC_W-1:0] e;
		case (op)
			OP_GD:   e = U_GD;
			OP_PD:   e = U_PD;
			OP_H:    e = U_H;
			OP_LR:   e = U_LR;
			OP_SR:   e = U_SR;
			OP_CR:   e = U_CR;
			OP_BT:   e = U_BT;
			default: e = U_NOP;
		endcase
		return e;
	endfunction

endpackage

>>> hdl/cmie_seq.sv
// Microcode sequencer: step counter, control table lookup, jumps and dispatch.
// Depends on cmie_pkg; drives the control word of cmie_dp.
module cmie_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            take,
	input  logic [1:0]      kind,
	input  cmie_pkg::flags_t flg,
	output cmie_pkg::ctl_t  ctl,
	output logic            busy
);
	import cmie_pkg::*;

	logic [UPC_W-1:0] upc_q, upc_d;
	logic             busy_q, busy_d;
	logic             hit;

	assign busy = busy_q;
	assign ctl  = busy_q ? ucode(upc_q) : ctl_idle();

	always_comb begin
		case (ctl.cnd)
			C_AWAIT:        hit = flg.await;
			C_NOT_AWAIT:    hit = !flg.await;
			C_STOP:         hit = flg.stop;
			C_BLK_BAD:      hit = !flg.blk_ok;
			C_ADDR_BAD:     hit = !flg.addr_ok;
			C_FULL:         hit = flg.full;
			C_NOT_CARD_END: hit = !flg.card_end;
			C_PD_MORE:      hit = flg.pd_more;
			default:        hit = 1'b0;
		endcase
	end

	always_comb begin
		upc_d  = upc_q;
		busy_d = busy_q;
		if (!busy_q) begin
			if (take) begin
				upc_d  = kind_entry(kind_t'(kind));
				busy_d = 1'b1;
			end
		end else begin
			case (ctl.nxt)
				N_SEQ:   upc_d = upc_q + 1'b1;
				N_JUMP:  upc_d = hit ? ctl.tgt : upc_q + 1'b1;
				N_OPMAP: upc_d = op_entry(flg.op);
				N_END:   busy_d = 1'b0;
				default: busy_d = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q  <= '0;
			busy_q <= 1'b0;
		end else begin
			upc_q  <= upc_d;
			busy_q <= busy_d;
		end
	end

endmodule

>>> hdl/cmie_dp.sv
// Datapath: main memory with valid bits, machine registers, operand decode
// and the registered result ports. Depends on cmie_pkg; steered by cmie_seq.
module cmie_dp (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             take,
	input  logic [7:0]       char_in,
	input  logic             end_of_line,
	input  cmie_pkg::ctl_t   ctl,
	output cmie_pkg::flags_t flg,
	output logic             strobe,
	output logic [7:0]       out_char,
	output logic             out_valid,
	output logic             last,
	output logic [1:0]       status,
	output logic [6:0]       counter_now,
	output logic             toggle_now
);
	import cmie_pkg::*;

	logic [31:0]    mem_q [MEM_WORDS];
	logic [MEM_WORDS-1:0] vld_q;
	logic [31:0]    rd_q, ir_q, gr_q;
	logic [7:0]     ch_q;
	logic           eol_q;
	logic           tog_q, halt_q, await_q;
	logic [AW-1:0]  ic_q, lwp_q;
	logic [1:0]     lbp_q;
	logic [8:0]     dfp_q;
	logic [5:0]     fcnt_q, j_q;

	logic [7:0]     c2, c3, d2, d3, pd_byte;
	logic           dig2, dig3;
	logic [AW-1:0]  blk, oper, maddr;
	logic [1:0]     lane;
	logic [31:0]    merged, wdata;
	logic [AW-1:0]  ic_d;
	logic           tog_d, fire;

	logic           strobe_q;
	logic [7:0]     out_char_q;
	logic           out_valid_q, last_q, toggle_q;
	logic [1:0]     status_q;
	logic [6:0]     counter_q;

	assign c2   = ir_q[23:16];
	assign c3   = ir_q[31:24];
	assign d2   = c2 - CH_ZERO;
	assign d3   = c3 - CH_ZERO;
	assign dig2 = (c2 >= CH_ZERO) && (c2 <= CH_NINE);
	assign dig3 = (c3 >= CH_ZERO) && (c3 <= CH_NINE);
	assign blk  = {3'b000, d2[3:0]} * AW'(BLOCK_WORDS);
	assign oper = {3'b000, d2[3:0]} * AW'(10) + {3'b000, d3[3:0]};

	assign flg.await    = await_q;
	assign flg.stop     = halt_q || (ic_q >= AW'(MEM_WORDS));
	assign flg.blk_ok   = dig2 && (({1'b0, blk} + 8'(BLOCK_WORDS)) <= 8'(MEM_WORDS));
	assign flg.addr_ok  = dig2 && dig3 && (oper < AW'(MEM_WORDS));
	assign flg.full     = lwp_q >= AW'(MEM_WORDS);
	assign flg.card_end = eol_q || (fcnt_q == 6'(BLOCK_BYTES - 1));
	assign flg.pd_more  = j_q != 6'(BLOCK_BYTES - 1);
	assign flg.op       = ir_q[7:0];

	always_comb begin
		case (ctl.asel)
			A_IC:    maddr = ic_q;
			A_LOAD:  maddr = lwp_q;
			A_FILL:  maddr = dfp_q[8:2];
			A_OPER:  maddr = oper;
			A_PD:    maddr = blk + {3'b000, j_q[5:2]};
			default: maddr = ic_q;
		endcase
		lane   = (ctl.asel == A_FILL) ? dfp_q[1:0] : lbp_q;
		merged = rd_q;
		merged[{lane, 3'b000} +: 8] = ch_q;
		wdata  = (ctl.dsel == D_GR) ? gr_q : merged;
		pd_byte = rd_q[{j_q[1:0], 3'b000} +: 8];
	end

	always_comb begin
		ic_d  = ic_q;
		tog_d = tog_q;
		case (ctl.act)
			ACT_CLEAR: begin
				ic_d  = '0;
				tog_d = 1'b0;
			end
			ACT_FETCH: ic_d = ic_q + 1'b1;
			ACT_CMP:   tog_d = (rd_q == gr_q);
			ACT_BT: begin
				if (tog_q) ic_d = oper;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.wr && (maddr < AW'(MEM_WORDS)))
			mem_q[maddr] <= wdata;
		if (ctl.rd)
			rd_q <= (maddr < AW'(MEM_WORDS)) ? (vld_q[maddr] ? mem_q[maddr] : '0) : '0;
		if (take) begin
			ch_q  <= char_in;
			eol_q <= end_of_line;
		end
		if (ctl.act == ACT_FETCH)
			ir_q <= rd_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			gr_q    <= '0;
			tog_q   <= 1'b0;
			ic_q    <= '0;
			halt_q  <= 1'b0;
			lwp_q   <= '0;
			lbp_q   <= '0;
			dfp_q   <= '0;
			await_q <= 1'b0;
			fcnt_q  <= '0;
			j_q     <= '0;
		end else begin
			ic_q  <= ic_d;
			tog_q <= tog_d;
			if (ctl.wr && (maddr < AW'(MEM_WORDS)))
				vld_q[maddr] <= 1'b1;
			case (ctl.act)
				ACT_CLEAR: begin
					vld_q   <= '0;
					gr_q    <= '0;
					halt_q  <= 1'b0;
					lwp_q   <= '0;
					lbp_q   <= '0;
					dfp_q   <= '0;
					await_q <= 1'b0;
					fcnt_q  <= '0;
				end
				ACT_LOAD_ADV: begin
					if (lbp_q == 2'd3) begin
						lbp_q <= '0;
						lwp_q <= lwp_q + 1'b1;
					end else begin
						lbp_q <= eol_q ? 2'd0 : lbp_q + 1'b1;
					end
				end
				ACT_LOAD_EOL: begin
					if (eol_q) lbp_q <= '0;
				end
				ACT_FILL_ADV: begin
					dfp_q  <= dfp_q + 1'b1;
					fcnt_q <= fcnt_q + 1'b1;
				end
				ACT_CARD_DONE: await_q <= 1'b0;
				ACT_SET_GD: begin
					await_q <= 1'b1;
					dfp_q   <= {blk, 2'b00};
					fcnt_q  <= '0;
				end
				ACT_PD_INIT: j_q <= '0;
				ACT_PD_ADV:  j_q <= j_q + 1'b1;
				ACT_HALT:    halt_q <= 1'b1;
				ACT_LR:      gr_q <= rd_q;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (ctl.emit)
			EM_PLAIN:  fire = 1'b1;
			EM_NL:     fire = 1'b1;
			EM_PDBYTE: fire = (pd_byte != 8'h00);
			default:   fire = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) strobe_q <= 1'b0;
		else         strobe_q <= fire;
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			case (ctl.emit)
				EM_NL:     out_char_q <= CH_NL;
				EM_PDBYTE: out_char_q <= pd_byte;
				default:   out_char_q <= 8'h00;
			endcase
			out_valid_q <= (ctl.emit != EM_PLAIN);
			last_q      <= ctl.last;
			status_q    <= ctl.stat;
			counter_q   <= ic_d;
			toggle_q    <= tog_d;
		end
	end

	assign strobe      = strobe_q;
	assign out_char    = out_char_q;
	assign out_valid   = out_valid_q;
	assign last        = last_q;
	assign status      = status_q;
	assign counter_now = counter_q;
	assign toggle_now  = toggle_q;

endmodule

>>> hdl/card_machine_instruction_executor_unit.sv
// Card machine instruction executor, top level: microcode sequencer and datapath.
// Depends on cmie_pkg, cmie_seq and cmie_dp.
//
//  channel  | handshake           | payload
//  ---------+---------------------+---------------------------------------------
//  command  | start, busy         | kind, char_in, end_of_line
//  result   | strobe (no stall)   | out_char, out_valid, last, status,
//           |                     | counter_now, toggle_now
//
// One item at a time; busy is high from the edge that takes start until the
// last microstep ends. There is one memory read port, and its read data is
// registered. Each result is registered and shows in the cycle after its
// microstep. Reset clears the counters, flags, pointers, strobe and memory valid
// bits, but not the memory words, the fetched or read words or the result payload.
module card_machine_instruction_executor_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [1:0] kind,
	input  logic [7:0] char_in,
	input  logic       end_of_line,
	output logic       strobe,
	output logic [7:0] out_char,
	output logic       out_valid,
	output logic       last,
	output logic [1:0] status,
	output logic [6:0] counter_now,
	output logic       toggle_now
);
	import cmie_pkg::*;

	ctl_t   ctl;
	flags_t flg;
	logic   take;

	assign take = start && !busy;

	cmie_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.kind   (kind),
		.flg    (flg),
		.ctl    (ctl),
		.busy   (busy)
	);

	cmie_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.char_in     (char_in),
		.end_of_line (end_of_line),
		.ctl         (ctl),
		.flg         (flg),
		.strobe      (strobe),
		.out_char    (out_char),
		.out_valid   (out_valid),
		.last        (last),
		.status      (status),
		.counter_now (counter_now),
		.toggle_now  (toggle_now)
	);

endmodule
